// ===== hdl/three_point_circle_center_defines.svh =====
// Assertion macros for the circle center block.
`ifndef THREE_POINT_CIRCLE_CENTER_DEFINES_SVH
`define THREE_POINT_CIRCLE_CENTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPCC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tpcc assertion failed");

// Next-cycle implication, checked outside reset.
`define TPCC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tpcc assertion failed");

`endif

// ===== hdl/tpcc_pkg.sv =====
// Shared widths, status codes and types of the circle center block.
package tpcc_pkg;

    localparam int COORD_W       = 16;
    localparam int DIFF_W        = 17;
    localparam int SQ_W          = 34;
    localparam int DEN_W         = 36;
    localparam int MUL_W         = 51;
    localparam int NUM_W         = 52;
    localparam int MAG_N_W       = 50;
    localparam int RES_W         = 35;
    localparam int SAT_SHIFT     = 33;
    localparam int FRAC_BITS_DEF = 8;
    localparam int OUT_W         = 32;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_NO_CIRCLE = 2'd1,
        ST_SAT       = 2'd2
    } status_t;

    // Per-item side information that rides along the divider chain.
    typedef struct packed {
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic [1:0]                neg;
        logic [1:0]                big;
        logic                      coll;
    } side_t;

endpackage

// ===== hdl/tpcc_pt_if.sv =====
// Input channel: three points.
interface tpcc_pt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_a_x;
    logic signed [15:0] point_a_y;
    logic signed [15:0] point_b_x;
    logic signed [15:0] point_b_y;
    logic signed [15:0] point_c_x;
    logic signed [15:0] point_c_y;

    modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y,
                    point_c_x, point_c_y, input ready);
    modport sink   (input valid, point_a_x, point_a_y, point_b_x, point_b_y,
                    point_c_x, point_c_y, output ready);
endinterface

// ===== hdl/tpcc_ctr_if.sv =====
// Output channel: circle center and status.
interface tpcc_ctr_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [1:0]         status;

    modport source (output valid, center_x, center_y, status, input ready);
    modport sink   (input valid, center_x, center_y, status, output ready);
endinterface

// ===== hdl/tpcc_front.sv =====
// Front pipeline: deltas, products, numerators, magnitudes, divider setup.
module tpcc_front
    import tpcc_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF,
    parameter int QW            = SAT_SHIFT + FRACTION_BITS
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COORD_W-1:0]    ax,
    input  logic signed [COORD_W-1:0]    ay,
    input  logic signed [COORD_W-1:0]    bx,
    input  logic signed [COORD_W-1:0]    by,
    input  logic signed [COORD_W-1:0]    cx,
    input  logic signed [COORD_W-1:0]    cy,
    output logic                         out_valid,
    output side_t                        out_side,
    output logic [1:0][RES_W-1:0]        out_r,
    output logic [1:0][QW-1:0]           out_dq,
    output logic [RES_W-1:0]             out_d
);

    logic [6:0] vld_reg;

    // stage 1: coordinates relative to the first point
    logic signed [COORD_W-1:0] s1_ax_reg, s1_ay_reg;
    logic signed [DIFF_W-1:0]  s1_bx_reg, s1_by_reg, s1_cx_reg, s1_cy_reg;
    // stage 2: products
    logic signed [COORD_W-1:0] s2_ax_reg, s2_ay_reg;
    logic signed [DIFF_W-1:0]  s2_bx_reg, s2_by_reg, s2_cx_reg, s2_cy_reg;
    logic signed [SQ_W-1:0]    s2_bxcy_reg, s2_bycx_reg;
    logic signed [SQ_W-1:0]    s2_bxbx_reg, s2_byby_reg, s2_cxcx_reg, s2_cycy_reg;
    // stage 3: determinant and squared lengths
    logic signed [COORD_W-1:0] s3_ax_reg, s3_ay_reg;
    logic signed [DIFF_W-1:0]  s3_bx_reg, s3_by_reg, s3_cx_reg, s3_cy_reg;
    logic signed [DEN_W-1:0]   s3_den_reg;
    logic signed [SQ_W-1:0]    s3_b2_reg, s3_c2_reg;
    // stage 4: numerator terms
    logic signed [COORD_W-1:0] s4_ax_reg, s4_ay_reg;
    logic signed [DEN_W-1:0]   s4_den_reg;
    logic signed [MUL_W-1:0]   s4_t1_reg, s4_t2_reg, s4_t3_reg, s4_t4_reg;
    // stage 5: numerators
    logic signed [COORD_W-1:0] s5_ax_reg, s5_ay_reg;
    logic signed [DEN_W-1:0]   s5_den_reg;
    logic signed [NUM_W-1:0]   s5_nx_reg, s5_ny_reg;
    // stage 6: magnitudes and signs
    side_t                     s6_side_reg;
    logic [MAG_N_W-1:0]        s6_nx_reg, s6_ny_reg;
    logic [RES_W-1:0]          s6_d_reg;
    // stage 7: divider entry
    side_t                     s7_side_reg;
    logic [1:0][RES_W-1:0]     s7_r_reg;
    logic [1:0][QW-1:0]        s7_dq_reg;
    logic [RES_W-1:0]          s7_d_reg;

    logic signed [NUM_W-1:0]   nx_abs, ny_abs;
    logic signed [DEN_W-1:0]   den_abs;
    side_t                     s6_side_next;
    side_t                     s7_side_next;

    // magnitudes of numerators and determinant
    always_comb
    begin
        nx_abs  = s5_nx_reg[NUM_W-1] ? -s5_nx_reg : s5_nx_reg;
        ny_abs  = s5_ny_reg[NUM_W-1] ? -s5_ny_reg : s5_ny_reg;
        den_abs = s5_den_reg[DEN_W-1] ? -s5_den_reg : s5_den_reg;
        s6_side_next.base_x = s5_ax_reg;
        s6_side_next.base_y = s5_ay_reg;
        s6_side_next.neg    = {s5_ny_reg[NUM_W-1] ^ s5_den_reg[DEN_W-1],
                               s5_nx_reg[NUM_W-1] ^ s5_den_reg[DEN_W-1]};
        s6_side_next.big    = 2'b00;
        s6_side_next.coll   = (s5_den_reg == '0);
    end

    // quotient of 2^SAT_SHIFT or more always saturates
    always_comb
    begin
        s7_side_next     = s6_side_reg;
        s7_side_next.big = {RES_W'(s6_ny_reg >> SAT_SHIFT) >= s6_d_reg,
                            RES_W'(s6_nx_reg >> SAT_SHIFT) >= s6_d_reg};
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ax_reg   <= ax;
            s1_ay_reg   <= ay;
            s1_bx_reg   <= DIFF_W'(bx) - DIFF_W'(ax);
            s1_by_reg   <= DIFF_W'(by) - DIFF_W'(ay);
            s1_cx_reg   <= DIFF_W'(cx) - DIFF_W'(ax);
            s1_cy_reg   <= DIFF_W'(cy) - DIFF_W'(ay);

            s2_ax_reg   <= s1_ax_reg;
            s2_ay_reg   <= s1_ay_reg;
            s2_bx_reg   <= s1_bx_reg;
            s2_by_reg   <= s1_by_reg;
            s2_cx_reg   <= s1_cx_reg;
            s2_cy_reg   <= s1_cy_reg;
            s2_bxcy_reg <= SQ_W'(s1_bx_reg) * SQ_W'(s1_cy_reg);
            s2_bycx_reg <= SQ_W'(s1_by_reg) * SQ_W'(s1_cx_reg);
            s2_bxbx_reg <= SQ_W'(s1_bx_reg) * SQ_W'(s1_bx_reg);
            s2_byby_reg <= SQ_W'(s1_by_reg) * SQ_W'(s1_by_reg);
            s2_cxcx_reg <= SQ_W'(s1_cx_reg) * SQ_W'(s1_cx_reg);
            s2_cycy_reg <= SQ_W'(s1_cy_reg) * SQ_W'(s1_cy_reg);

            s3_ax_reg   <= s2_ax_reg;
            s3_ay_reg   <= s2_ay_reg;
            s3_bx_reg   <= s2_bx_reg;
            s3_by_reg   <= s2_by_reg;
            s3_cx_reg   <= s2_cx_reg;
            s3_cy_reg   <= s2_cy_reg;
            s3_den_reg  <= (DEN_W'(s2_bxcy_reg) - DEN_W'(s2_bycx_reg)) <<< 1;
            s3_b2_reg   <= s2_bxbx_reg + s2_byby_reg;
            s3_c2_reg   <= s2_cxcx_reg + s2_cycy_reg;

            s4_ax_reg   <= s3_ax_reg;
            s4_ay_reg   <= s3_ay_reg;
            s4_den_reg  <= s3_den_reg;
            s4_t1_reg   <= MUL_W'(s3_cy_reg) * MUL_W'(s3_b2_reg);
            s4_t2_reg   <= MUL_W'(s3_by_reg) * MUL_W'(s3_c2_reg);
            s4_t3_reg   <= MUL_W'(s3_bx_reg) * MUL_W'(s3_c2_reg);
            s4_t4_reg   <= MUL_W'(s3_cx_reg) * MUL_W'(s3_b2_reg);

            s5_ax_reg   <= s4_ax_reg;
            s5_ay_reg   <= s4_ay_reg;
            s5_den_reg  <= s4_den_reg;
            s5_nx_reg   <= NUM_W'(s4_t1_reg) - NUM_W'(s4_t2_reg);
            s5_ny_reg   <= NUM_W'(s4_t3_reg) - NUM_W'(s4_t4_reg);

            s6_side_reg <= s6_side_next;
            s6_nx_reg   <= nx_abs[MAG_N_W-1:0];
            s6_ny_reg   <= ny_abs[MAG_N_W-1:0];
            s6_d_reg    <= den_abs[RES_W-1:0];

            s7_side_reg      <= s7_side_next;
            s7_r_reg[0]      <= RES_W'(s6_nx_reg >> SAT_SHIFT);
            s7_r_reg[1]      <= RES_W'(s6_ny_reg >> SAT_SHIFT);
            s7_dq_reg[0]     <= QW'(s6_nx_reg[SAT_SHIFT-1:0]) << FRACTION_BITS;
            s7_dq_reg[1]     <= QW'(s6_ny_reg[SAT_SHIFT-1:0]) << FRACTION_BITS;
            s7_d_reg         <= s6_d_reg;
        end
    end

    assign out_valid = vld_reg[6];
    assign out_side  = s7_side_reg;
    assign out_r     = s7_r_reg;
    assign out_dq    = s7_dq_reg;
    assign out_d     = s7_d_reg;

endmodule

// ===== hdl/tpcc_cell.sv =====
// Divider cell: one restoring quotient bit for the x and y lanes.
module tpcc_cell
    import tpcc_pkg::*;
#(
    parameter int QW = SAT_SHIFT + FRAC_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  side_t                 in_side,
    input  logic [1:0][RES_W-1:0] in_r,
    input  logic [1:0][QW-1:0]    in_dq,
    input  logic [RES_W-1:0]      in_d,
    output logic                  out_valid,
    output side_t                 out_side,
    output logic [1:0][RES_W-1:0] out_r,
    output logic [1:0][QW-1:0]    out_dq,
    output logic [RES_W-1:0]      out_d
);

    logic                  valid_reg;
    side_t                 side_reg;
    logic [1:0][RES_W-1:0] r_reg, r_next;
    logic [1:0][QW-1:0]    dq_reg, dq_next;
    logic [RES_W-1:0]      d_reg;
    logic [1:0][RES_W:0]   trial;
    logic [1:0]            ge;

    // shift in next dividend bit, compare, subtract; quotient bit enters at the bottom
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            trial[i]   = {in_r[i], in_dq[i][QW-1]};
            ge[i]      = trial[i] >= {1'b0, in_d};
            r_next[i]  = ge[i] ? RES_W'(trial[i] - {1'b0, in_d}) : RES_W'(trial[i]);
            dq_next[i] = {in_dq[i][QW-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            r_reg    <= r_next;
            dq_reg   <= dq_next;
            d_reg    <= in_d;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_r     = r_reg;
    assign out_dq    = dq_reg;
    assign out_d     = d_reg;

endmodule

// ===== hdl/tpcc_back.sv =====
// Back end: rounding, placement at the first point, clamping, output register.
module tpcc_back
    import tpcc_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF,
    parameter int QW            = SAT_SHIFT + FRACTION_BITS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  side_t                 in_side,
    input  logic [1:0][RES_W-1:0] in_r,
    input  logic [1:0][QW-1:0]    in_q,
    input  logic [RES_W-1:0]      in_d,
    output logic                  out_valid,
    tpcc_ctr_if.source            ctr
);

    localparam int TOT_W = QW + 3;
    localparam logic signed [TOT_W-1:0] MAX_T = TOT_W'(OUT_MAX);
    localparam logic signed [TOT_W-1:0] MIN_T = TOT_W'(OUT_MIN);

    logic                  b1_valid_reg;
    side_t                 b1_side_reg;
    logic [1:0][QW:0]      b1_m_reg, b1_m_next;
    logic [1:0][RES_W:0]   twice_r;
    logic [1:0]            inc;

    logic                          o_valid_reg;
    logic signed [OUT_W-1:0]       o_x_reg, o_x_next;
    logic signed [OUT_W-1:0]       o_y_reg, o_y_next;
    status_t                       o_st_reg, o_st_next;
    logic [1:0][TOT_W-1:0]         total;
    logic [1:0][TOT_W-1:0]         off;
    logic [1:0][TOT_W-1:0]         base;
    logic [1:0][OUT_W-1:0]         val;
    logic [1:0]                    sat;

    // round to nearest: ties up, i.e. away from zero for positive, toward zero for negative
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            twice_r[i]   = {in_r[i], 1'b0};
            inc[i]       = in_side.neg[i] ? (twice_r[i] >  {1'b0, in_d})
                                          : (twice_r[i] >= {1'b0, in_d});
            b1_m_next[i] = (QW+1)'(in_q[i]) + (QW+1)'(inc[i]);
        end
    end

    // signed offset plus base, clamp to 32 bits; collinear points give a zero center
    always_comb
    begin
        base[0] = TOT_W'(b1_side_reg.base_x) <<< FRACTION_BITS;
        base[1] = TOT_W'(b1_side_reg.base_y) <<< FRACTION_BITS;
        for (int i = 0; i < 2; i++)
        begin
            off[i]   = b1_side_reg.neg[i] ? -TOT_W'(b1_m_reg[i]) : TOT_W'(b1_m_reg[i]);
            total[i] = base[i] + off[i];
            if (b1_side_reg.big[i])
            begin
                sat[i] = 1'b1;
                val[i] = b1_side_reg.neg[i] ? OUT_MIN : OUT_MAX;
            end
            else if ($signed(total[i]) > MAX_T)
            begin
                sat[i] = 1'b1;
                val[i] = OUT_MAX;
            end
            else if ($signed(total[i]) < MIN_T)
            begin
                sat[i] = 1'b1;
                val[i] = OUT_MIN;
            end
            else
            begin
                sat[i] = 1'b0;
                val[i] = total[i][OUT_W-1:0];
            end
        end
        if (b1_side_reg.coll)
        begin
            o_x_next  = '0;
            o_y_next  = '0;
            o_st_next = ST_NO_CIRCLE;
        end
        else
        begin
            o_x_next  = val[0];
            o_y_next  = val[1];
            o_st_next = (sat != 2'b00) ? ST_SAT : ST_VALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= in_valid;
            o_valid_reg  <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_side_reg <= in_side;
            b1_m_reg    <= b1_m_next;
            o_x_reg     <= o_x_next;
            o_y_reg     <= o_y_next;
            o_st_reg    <= o_st_next;
        end
    end

    assign out_valid    = o_valid_reg;
    assign ctr.valid    = o_valid_reg;
    assign ctr.center_x = o_x_reg;
    assign ctr.center_y = o_y_reg;
    assign ctr.status   = o_st_reg;

endmodule

// ===== hdl/three_point_circle_center.sv =====
// Throughput: one item per cycle; the whole pipeline holds only while a result waits.
// Path: 7 setup stages, one divider cell per quotient bit (33 + FRACTION_BITS), 2 output stages.
// Reset: asynchronous, active low; clears all valid bits, so no result is pending after it.
// Circle through three points: top level.
module three_point_circle_center
    import tpcc_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    tpcc_pt_if.sink     pts,
    tpcc_ctr_if.source  ctr
);

    localparam int QW = SAT_SHIFT + FRACTION_BITS;

    logic                  en;
    logic                  out_valid;
    logic                  ch_valid [0:QW];
    side_t                 ch_side  [0:QW];
    logic [1:0][RES_W-1:0] ch_r     [0:QW];
    logic [1:0][QW-1:0]    ch_dq    [0:QW];
    logic [RES_W-1:0]      ch_d     [0:QW];

    // advance unless a finished result is stalled
    assign en        = !out_valid || ctr.ready;
    assign pts.ready = en;

    tpcc_front #(
        .FRACTION_BITS (FRACTION_BITS),
        .QW            (QW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pts.valid),
        .ax        (pts.point_a_x),
        .ay        (pts.point_a_y),
        .bx        (pts.point_b_x),
        .by        (pts.point_b_y),
        .cx        (pts.point_c_x),
        .cy        (pts.point_c_y),
        .out_valid (ch_valid[0]),
        .out_side  (ch_side[0]),
        .out_r     (ch_r[0]),
        .out_dq    (ch_dq[0]),
        .out_d     (ch_d[0])
    );

    // divider chain
    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        tpcc_cell #(
            .QW (QW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (ch_valid[k]),
            .in_side   (ch_side[k]),
            .in_r      (ch_r[k]),
            .in_dq     (ch_dq[k]),
            .in_d      (ch_d[k]),
            .out_valid (ch_valid[k+1]),
            .out_side  (ch_side[k+1]),
            .out_r     (ch_r[k+1]),
            .out_dq    (ch_dq[k+1]),
            .out_d     (ch_d[k+1])
        );
    end

    tpcc_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .QW            (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ch_valid[QW]),
        .in_side   (ch_side[QW]),
        .in_r      (ch_r[QW]),
        .in_q      (ch_dq[QW]),
        .in_d      (ch_d[QW]),
        .out_valid (out_valid),
        .ctr       (ctr)
    );

endmodule

// ===== hdl/tpcc_checker.sv =====
// Port-level checker for the circle center block, with its bind.
`include "three_point_circle_center_defines.svh"

module tpcc_checker
    import tpcc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] center_x,
    input logic signed [31:0] center_y,
    input logic [1:0]         status
);

    // a stalled result holds
    `TPCC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(center_x) && $stable(center_y) && $stable(status))

    // no input transfer while a result is stalled
    `TPCC_ASSERT_NOW(a_backpressure, clk, rst_n, out_valid && !out_ready, !in_ready)

    // collinear points give a zero center
    `TPCC_ASSERT_NOW(a_no_circle_zero, clk, rst_n, out_valid && (status == ST_NO_CIRCLE), (center_x == 0) && (center_y == 0))

    // only defined status codes
    `TPCC_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, (status == ST_VALID) || (status == ST_NO_CIRCLE) || (status == ST_SAT))

endmodule

bind three_point_circle_center tpcc_checker u_tpcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pts.ready),
    .out_valid (ctr.valid),
    .out_ready (ctr.ready),
    .center_x  (ctr.center_x),
    .center_y  (ctr.center_y),
    .status    (ctr.status)
);
